// ===== hw/rtl/was_pkg.sv =====
package was_pkg;

    localparam int NUM_ENTRIES = 256;
    localparam int IDX_W       = 8;
    localparam int CNT_W       = 9;
    localparam int WEIGHT_W    = 32;
    localparam int RAND_W      = 32;
    localparam int ACC_W       = 40;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_BUILD  = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_ZERO_SUM  = 2'd1;
    localparam logic [1:0] STAT_NOT_BUILT = 2'd2;

    typedef struct packed {
        logic [1:0]          action;
        logic [IDX_W-1:0]    entry_index;
        logic [WEIGHT_W-1:0] weight;
        logic [RAND_W-1:0]   random_value;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] sampled_index;
        logic [1:0]       status;
    } rsp_t;

    typedef struct packed {
        logic             capture;
        logic             sum_rd;
        logic             sum_fail;
        logic             sum_ok;
        logic             scan_start;
        logic             scan_rd;
        logic             commit;
        logic             tables_set;
        logic             smp_mul;
        logic             smp_rd;
        logic             smp_cmp;
        logic             out_load;
        logic [1:0]       out_status;
        logic [CNT_W-1:0] cnt_j;
        logic [CNT_W-1:0] cnt_i;
    } cmd_t;

    typedef struct packed {
        logic             tables_valid;
        logic             sum_zero;
        logic             out_free;
        logic [CNT_W-1:0] n;
    } sts_t;

endpackage

// ===== hw/rtl/walker_alias_sampler_top.sv =====
// A load or an unused action goes straight to the output step; a sample passes through
// product, table read with fraction multiply, compare and output.
// A build makes one sum pass, then N scans over the residual memory, one entry per
// cycle through its single read port.
// Throughput: one request at a time; the next is taken once the response is registered.
// Reset (rst_n, asynchronous, active low) sets N to 1 and clears table validity.
module walker_alias_sampler_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  was_pkg::req_t             req,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output was_pkg::rsp_t             rsp,
    input  logic                      cfg_write,
    input  logic [was_pkg::CNT_W-1:0] cfg_data
);

    // The controller sequences the sum, scan and commit passes of a build and
    // the steps of a sample; the datapath holds the memories and arithmetic.
    was_pkg::cmd_t cmd;
    was_pkg::sts_t sts;

    was_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_action (req.action),
        .req_stall  (req_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // The response register sits in the datapath, so a waiting response does
    // not hold back the controller beyond its final step.
    was_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .rsp_stall (rsp_stall)
    );

endmodule

// ===== hw/rtl/was_ctrl.sv =====
module was_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic [1:0]    req_action,
    output logic          req_stall,
    input  was_pkg::sts_t sts,
    output was_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SUM    = 4'd1;
    localparam logic [3:0] S_SUMW   = 4'd2;
    localparam logic [3:0] S_CHK    = 4'd3;
    localparam logic [3:0] S_PSTART = 4'd4;
    localparam logic [3:0] S_SCAN   = 4'd5;
    localparam logic [3:0] S_SCANW  = 4'd6;
    localparam logic [3:0] S_COMMIT = 4'd7;
    localparam logic [3:0] S_SMP1   = 4'd8;
    localparam logic [3:0] S_SMP2   = 4'd9;
    localparam logic [3:0] S_SMP3   = 4'd10;
    localparam logic [3:0] S_FIN    = 4'd11;

    logic [3:0]                state_reg, state_next;
    logic [was_pkg::CNT_W-1:0] j_reg, j_next, i_reg, i_next;
    logic [1:0]                stat_reg, stat_next;
    logic [was_pkg::CNT_W-1:0] last;

    assign last      = sts.n - was_pkg::CNT_W'(1);
    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        i_next     = i_reg;
        stat_next  = stat_reg;
        cmd            = '0;
        cmd.cnt_j      = j_reg;
        cmd.cnt_i      = i_reg;
        cmd.out_status = stat_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    stat_next   = was_pkg::STAT_OK;
                    state_next  = S_FIN;
                    if (req_action == was_pkg::ACT_BUILD)
                    begin
                        j_next     = '0;
                        state_next = S_SUM;
                    end
                    else if (req_action == was_pkg::ACT_SAMPLE)
                    begin
                        if (sts.tables_valid)
                            state_next = S_SMP1;
                        else
                            stat_next = was_pkg::STAT_NOT_BUILT;
                    end
                end
            end
            S_SUM:
            begin
                cmd.sum_rd = 1'b1;
                j_next     = j_reg + was_pkg::CNT_W'(1);
                if (j_reg == last)
                    state_next = S_SUMW;
            end
            S_SUMW:
                state_next = S_CHK;
            S_CHK:
            begin
                if (sts.sum_zero)
                begin
                    cmd.sum_fail = 1'b1;
                    stat_next    = was_pkg::STAT_ZERO_SUM;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.sum_ok = 1'b1;
                    i_next     = '0;
                    state_next = S_PSTART;
                end
            end
            S_PSTART:
            begin
                cmd.scan_start = 1'b1;
                j_next         = '0;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                j_next      = j_reg + was_pkg::CNT_W'(1);
                if (j_reg == last)
                    state_next = S_SCANW;
            end
            S_SCANW:
                state_next = S_COMMIT;
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                if (i_reg == last)
                begin
                    cmd.tables_set = 1'b1;
                    stat_next      = was_pkg::STAT_OK;
                    state_next     = S_FIN;
                end
                else
                begin
                    i_next     = i_reg + was_pkg::CNT_W'(1);
                    state_next = S_PSTART;
                end
            end
            S_SMP1:
            begin
                cmd.smp_mul = 1'b1;
                state_next  = S_SMP2;
            end
            S_SMP2:
            begin
                cmd.smp_rd = 1'b1;
                state_next = S_SMP3;
            end
            S_SMP3:
            begin
                cmd.smp_cmp = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            j_reg     <= '0;
            i_reg     <= '0;
            stat_reg  <= was_pkg::STAT_OK;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            i_reg     <= i_next;
            stat_reg  <= stat_next;
        end
    end

endmodule

// ===== hw/rtl/was_dp.sv =====
module was_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  was_pkg::req_t             req,
    input  logic                      cfg_write,
    input  logic [was_pkg::CNT_W-1:0] cfg_data,
    input  was_pkg::cmd_t             cmd,
    output was_pkg::sts_t             sts,
    output logic                      rsp_valid,
    output was_pkg::rsp_t             rsp,
    input  logic                      rsp_stall
);

    localparam int NE   = was_pkg::NUM_ENTRIES;
    localparam int IW   = was_pkg::IDX_W;
    localparam int CW   = was_pkg::CNT_W;
    localparam int WW   = was_pkg::WEIGHT_W;
    localparam int RW   = was_pkg::RAND_W;
    localparam int AW   = was_pkg::ACC_W;

    // Storage
    logic [WW-1:0] weight_mem [NE];
    logic [AW-1:0] resid_mem  [NE];
    logic [AW-1:0] cut_mem    [NE];
    logic [IW-1:0] alo_mem    [NE];
    logic [IW-1:0] ahi_mem    [NE];
    logic          avail_mem  [NE];

    logic [CW-1:0]   n_reg;
    logic            tables_valid_reg;
    logic [AW-1:0]   total_reg, sum_reg;
    was_pkg::req_t   req_reg;

    logic            w_vld_reg;
    logic [IW-1:0]   w_addr_reg;
    logic [WW-1:0]   w_data_reg;
    logic            r_vld_reg;
    logic [IW-1:0]   r_addr_reg;
    logic [AW-1:0]   r_data_reg;
    logic            r_avail_reg;

    logic            found_reg;
    logic [IW-1:0]   lo_reg, hi_reg;
    logic [AW-1:0]   rmin_reg, rmax_reg;

    logic [RW+CW-1:0] prod_reg;
    logic [RW+31:0]   pl_reg;
    logic [RW+AW-33:0] ph_reg;
    logic [AW-1:0]    cut_reg;
    logic [IW-1:0]    alo_reg, ahi_reg, pick_reg;

    logic            rsp_valid_reg;
    was_pkg::rsp_t   rsp_reg;

    logic [CW-1:0]    n_next, k_raw, k_sel;
    logic [AW:0]      pair_sum;
    logic [AW-1:0]    resid_upd;
    logic             cand;
    logic [RW+AW-1:0] lhs, rhs;

    always_comb
    begin
        if (cfg_data == '0)
            n_next = CW'(1);
        else if (cfg_data > CW'(NE))
            n_next = CW'(NE);
        else
            n_next = cfg_data;
    end

    assign pair_sum  = {1'b0, rmax_reg} + {1'b0, rmin_reg};
    assign resid_upd = (pair_sum >= {1'b0, total_reg}) ?
                       AW'(pair_sum - {1'b0, total_reg}) : '0;
    assign cand      = r_vld_reg && r_avail_reg;

    assign k_raw = prod_reg[RW+CW-1:RW];
    assign k_sel = (k_raw >= n_reg) ? (n_reg - CW'(1)) : k_raw;

    // Fraction times total compared against cutoff scaled by 2^RW.
    assign lhs = (RW+AW)'(pl_reg) + {ph_reg, 32'b0};
    assign rhs = {cut_reg, {RW{1'b0}}};

    assign sts.tables_valid = tables_valid_reg;
    assign sts.sum_zero     = (sum_reg == '0);
    assign sts.out_free     = !rsp_valid_reg || !rsp_stall;
    assign sts.n            = n_reg;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg            <= CW'(1);
            tables_valid_reg <= 1'b0;
            total_reg        <= '0;
            w_vld_reg        <= 1'b0;
            r_vld_reg        <= 1'b0;
            found_reg        <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            w_vld_reg <= cmd.sum_rd;
            r_vld_reg <= cmd.scan_rd;
            if (cfg_write)
            begin
                n_reg            <= n_next;
                tables_valid_reg <= 1'b0;
            end
            else if (cmd.sum_fail)
                tables_valid_reg <= 1'b0;
            else if (cmd.tables_set)
                tables_valid_reg <= 1'b1;
            if (cmd.sum_ok)
                total_reg <= sum_reg;
            if (cmd.scan_start)
                found_reg <= 1'b0;
            else if (cand)
                found_reg <= 1'b1;
            if (cmd.out_load)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Payload and memories
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
            sum_reg <= '0;
            if (req.action == was_pkg::ACT_LOAD)
                weight_mem[req.entry_index] <= req.weight;
        end
        else if (w_vld_reg)
            sum_reg <= sum_reg + AW'(w_data_reg);

        w_addr_reg  <= cmd.cnt_j[IW-1:0];
        w_data_reg  <= weight_mem[cmd.cnt_j[IW-1:0]];
        r_addr_reg  <= cmd.cnt_j[IW-1:0];
        r_data_reg  <= resid_mem[cmd.cnt_j[IW-1:0]];
        r_avail_reg <= avail_mem[cmd.cnt_j[IW-1:0]];

        // Every flag in use is set by the sum pass before any scan reads it.
        if (w_vld_reg)
            avail_mem[w_addr_reg] <= 1'b1;
        else if (cmd.commit)
            avail_mem[lo_reg] <= 1'b0;

        if (w_vld_reg)
            resid_mem[w_addr_reg] <= AW'(w_data_reg) * AW'(n_reg);
        else if (cmd.commit)
            resid_mem[hi_reg] <= resid_upd;

        if (cand)
        begin
            if (!found_reg || r_data_reg < rmin_reg)
            begin
                lo_reg   <= r_addr_reg;
                rmin_reg <= r_data_reg;
            end
            if (!found_reg || r_data_reg > rmax_reg)
            begin
                hi_reg   <= r_addr_reg;
                rmax_reg <= r_data_reg;
            end
        end

        if (cmd.commit)
        begin
            cut_mem[cmd.cnt_i[IW-1:0]] <= rmin_reg;
            alo_mem[cmd.cnt_i[IW-1:0]] <= lo_reg;
            ahi_mem[cmd.cnt_i[IW-1:0]] <= hi_reg;
        end

        if (cmd.smp_mul)
            prod_reg <= req_reg.random_value * n_reg;
        if (cmd.smp_rd)
        begin
            cut_reg <= cut_mem[k_sel[IW-1:0]];
            alo_reg <= alo_mem[k_sel[IW-1:0]];
            ahi_reg <= ahi_mem[k_sel[IW-1:0]];
            pl_reg  <= prod_reg[RW-1:0] * total_reg[31:0];
            ph_reg  <= prod_reg[RW-1:0] * total_reg[AW-1:32];
        end
        if (cmd.smp_cmp)
            pick_reg <= (lhs < rhs) ? alo_reg : ahi_reg;

        if (cmd.out_load)
        begin
            rsp_reg.status <= cmd.out_status;
            if (req_reg.action == was_pkg::ACT_SAMPLE && cmd.out_status == was_pkg::STAT_OK)
                rsp_reg.sampled_index <= pick_reg;
            else
                rsp_reg.sampled_index <= '0;
        end
    end

endmodule
